// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same check, also evaluated during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/arp_pkg.sv
`default_nettype none

package arp_pkg;

	localparam int unsigned IN_TDATA_W  = 320;
	localparam int unsigned OUT_TDATA_W = 72;

	// ELF relocation type numbers
	localparam logic [31:0] R_NONE             = 32'd0;
	localparam logic [31:0] R_ABS64            = 32'd257;
	localparam logic [31:0] R_ADR_PREL_PG_HI21 = 32'd275;
	localparam logic [31:0] R_ADD_ABS_LO12_NC  = 32'd277;
	localparam logic [31:0] R_JUMP26           = 32'd282;
	localparam logic [31:0] R_CALL26           = 32'd283;
	localparam logic [31:0] R_LDST16_LO12_NC   = 32'd284;
	localparam logic [31:0] R_LDST32_LO12_NC   = 32'd285;
	localparam logic [31:0] R_LDST64_LO12_NC   = 32'd286;

	localparam logic [31:0] BR_FIELD_MASK    = 32'h03ff_ffff;
	localparam logic [31:0] IMM12_FIELD_MASK = 32'h003f_fc00;
	localparam logic [31:0] ADR_FIELD_MASK   = 32'h60ff_ffe0;
	localparam logic [11:0] PAGE_LOW_MASK    = 12'hfff;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_W32  = 2'd1,
		KIND_W64  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OVF = 2'd1,
		ST_BAD = 2'd2
	} stat_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ABS64,
		OP_ADR,
		OP_ADD12,
		OP_BR,
		OP_LDST16,
		OP_LDST32,
		OP_LDST64,
		OP_BAD
	} op_t;

	// Decoded relocation after the address sums
	typedef struct packed {
		op_t         op;
		logic [63:0] sa;
		logic [63:0] p;
		logic [31:0] word;
	} mid_t;

	typedef struct packed {
		logic [63:0] value;
		kind_t       kind;
		stat_t       status;
	} res_t;

	function automatic op_t decode_type(input logic [31:0] t);
		op_t op;
		unique case (t)
			R_NONE:             op = OP_NONE;
			R_ABS64:            op = OP_ABS64;
			R_ADR_PREL_PG_HI21: op = OP_ADR;
			R_ADD_ABS_LO12_NC:  op = OP_ADD12;
			R_JUMP26,
			R_CALL26:           op = OP_BR;
			R_LDST16_LO12_NC:   op = OP_LDST16;
			R_LDST32_LO12_NC:   op = OP_LDST32;
			R_LDST64_LO12_NC:   op = OP_LDST64;
			default:            op = OP_BAD;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

// File: sv/arp_calc.sv
`default_nettype none

// Page/branch displacement, range checks and instruction field merge.
module arp_calc (
	input  var arp_pkg::mid_t mid,
	output var arp_pkg::res_t res
);

	logic [51:0] pg_diff;
	logic [63:0] br_x;
	logic        adr_ok;
	logic        br_ok;
	logic [20:0] adr_f;
	logic [31:0] adr_word;
	logic [31:0] br_word;
	logic [11:0] imm;
	logic [31:0] imm_word;

	// Page(S+A) - Page(P) computed on the page numbers; low 12 bits are zero
	assign pg_diff = mid.sa[63:12] - mid.p[63:12];
	assign br_x    = mid.sa - mid.p;

	// signed 33-bit range: bits 63..32 of the byte difference all equal
	assign adr_ok = (&pg_diff[51:20]) | ~(|pg_diff[51:20]);
	assign br_ok  = (mid.sa[1:0] == mid.p[1:0])
		&& ((&br_x[63:27]) | ~(|br_x[63:27]));

	assign adr_f    = pg_diff[20:0];
	assign adr_word = (mid.word & ~arp_pkg::ADR_FIELD_MASK)
		| {1'b0, adr_f[1:0], 5'd0, adr_f[20:2], 5'd0};
	assign br_word  = (mid.word & ~arp_pkg::BR_FIELD_MASK) | {6'd0, br_x[27:2]};

	always_comb begin
		unique case (mid.op)
			arp_pkg::OP_LDST16: imm = {1'b0, mid.sa[11:1]};
			arp_pkg::OP_LDST32: imm = {2'b0, mid.sa[11:2]};
			arp_pkg::OP_LDST64: imm = {3'b0, mid.sa[11:3]};
			default:            imm = mid.sa[11:0] & arp_pkg::PAGE_LOW_MASK;
		endcase
	end

	assign imm_word = (mid.word & ~arp_pkg::IMM12_FIELD_MASK) | {10'd0, imm, 10'd0};

	always_comb begin
		res.value  = '0;
		res.kind   = arp_pkg::KIND_NONE;
		res.status = arp_pkg::ST_OK;
		unique case (mid.op)
			arp_pkg::OP_NONE: begin
			end
			arp_pkg::OP_ABS64: begin
				res.value = mid.sa;
				res.kind  = arp_pkg::KIND_W64;
			end
			arp_pkg::OP_ADR: begin
				if (adr_ok) begin
					res.value = {32'd0, adr_word};
					res.kind  = arp_pkg::KIND_W32;
				end else begin
					res.status = arp_pkg::ST_OVF;
				end
			end
			arp_pkg::OP_BR: begin
				if (br_ok) begin
					res.value = {32'd0, br_word};
					res.kind  = arp_pkg::KIND_W32;
				end else begin
					res.status = arp_pkg::ST_OVF;
				end
			end
			arp_pkg::OP_ADD12,
			arp_pkg::OP_LDST16,
			arp_pkg::OP_LDST32,
			arp_pkg::OP_LDST64: begin
				res.value = {32'd0, imm_word};
				res.kind  = arp_pkg::KIND_W32;
			end
			default: begin
				res.status = arp_pkg::ST_BAD;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: sv/aarch64_reloc_patch.sv
// channel   dir  bits  contents
// s_axis    in   320   one relocation per transfer
// m_axis    out  72    patched value, write kind, status
//
// Three register stages: input, address sums plus type decode, result.
// One transfer is accepted every cycle unless all stages hold items and m_axis stalls.
// Each stage holds one item and moves when the stage after it is free or
// drains, so a stalled m_axis fills the stages before s_axis_tready drops.
// Reset clears the stage valid flags only.
`default_nettype none

`include "assert_macros.svh"

module aarch64_reloc_patch (
	input  var logic                              clk,
	input  var logic                              arst_n,
	input  var logic                              s_axis_tvalid,
	output var logic                              s_axis_tready,
	// reloc_type[31:0], symbol_value[95:32], addend[159:96],
	// section_address[223:160], place_offset[287:224], original_word[319:288]
	input  var logic [arp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output var logic                              m_axis_tvalid,
	input  var logic                              m_axis_tready,
	// patched_value[63:0], write_kind[65:64], status[67:66], zero[71:68]
	output var logic [arp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

	logic                             valid_s1;
	logic                             valid_s2;
	logic                             valid_s3;
	logic [arp_pkg::IN_TDATA_W-1:0]  in_s1;
	arp_pkg::mid_t                    mid_s2;
	arp_pkg::res_t                    res_s3;
	arp_pkg::mid_t                    mid_d;
	arp_pkg::res_t                    res_d;
	logic                             adv1;
	logic                             adv2;
	logic                             adv3;

	assign adv3 = !valid_s3 || m_axis_tready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= s_axis_tvalid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		mid_d.op   = arp_pkg::decode_type(in_s1[31:0]);
		mid_d.sa   = in_s1[95:32] + in_s1[159:96];
		mid_d.p    = in_s1[223:160] + in_s1[287:224];
		mid_d.word = in_s1[319:288];
	end

	arp_calc u_calc (
		.mid (mid_s2),
		.res (res_d)
	);

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) in_s1  <= s_axis_tdata;
		if (adv2 && valid_s1)      mid_s2 <= mid_d;
		if (adv3 && valid_s2)      res_s3 <= res_d;
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {4'd0, res_s3.status, res_s3.kind, res_s3.value};

	`ASSERT_CLK(a_accept_loads, (s_axis_tvalid && s_axis_tready) |=> valid_s1,
		"accepted transfer did not enter the input stage")
	`ASSERT_CLK(a_write_ok, (m_axis_tvalid && m_axis_tdata[65:64] != arp_pkg::KIND_NONE)
		|-> (m_axis_tdata[67:66] == arp_pkg::ST_OK), "write issued with error status")
	`ASSERT_CLK(a_err_zero, (m_axis_tvalid && m_axis_tdata[67:66] != arp_pkg::ST_OK)
		|-> (m_axis_tdata[65:64] == arp_pkg::KIND_NONE && m_axis_tdata[63:0] == 64'd0),
		"error result carries data")
	`ASSERT_CLK(a_w32_upper, (m_axis_tvalid && m_axis_tdata[65:64] == arp_pkg::KIND_W32)
		|-> (m_axis_tdata[63:32] == 32'd0), "32-bit write with upper bits set")
	`ASSERT_CLK_ALWAYS(a_ready_when_empty, (!valid_s1 || !valid_s2 || !valid_s3)
		|-> s_axis_tready, "input stalled with a free stage")

endmodule

`default_nettype wire
